// ----- sv/cbts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit timing search package
// Shared widths, defaults, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cbts_pkg;

   // Field widths of the ports.
   localparam int OSC_W      = 27;
   localparam int RATE_W     = 20;
   localparam int PRESC_W    = 7;
   localparam int QUANTA_W   = 5;
   localparam int BITRATE_W  = 24;

   // The CAN clock is half the oscillator, so it loses one bit.
   localparam int CLK_W      = OSC_W - 1;

   // Reset value of the requested bit rate register.
   localparam logic [RATE_W-1:0] RATE_RESET = 20'd615000;

   // Default search limits.
   localparam int MAX_PRESCALER_DEF = 64;
   localparam int MAX_QUANTA_DEF    = 25;
   localparam int MIN_QUANTA_DEF    = 5;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP_MUL,
      ST_STEP_CHK,
      ST_SEARCH_WAIT,
      ST_EVAL,
      ST_FIN_MUL,
      ST_FIN_DIV,
      ST_FIN_WAIT,
      ST_DONE
   } cbts_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the beat and reset the search
      logic mul_step;    // step = rate * quanta
      logic div_start;   // launch the shared divider
      logic div_final;   // divider divisor is the final product
      logic eval;        // score both prescaler candidates
      logic dec_q;       // move to the next quanta value
      logic mul_final;   // final divisor = best prescaler * best quanta
      logic finish;      // register the result beat
   } cbts_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic skip;        // no search possible for this quanta value
      logic div_done;    // divider result is ready
      logic stop;        // search ends after this evaluation
      logic q_last;      // current quanta value is the last one
   } cbts_status_type;

endpackage

// ----- sv/cbts_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit timing search divider
// Restoring unsigned divider, one quotient bit per cycle, with remainder.
// ----------------------------------------------------------------------------
module cbts_div
   import cbts_pkg::*;
#(
   parameter int DIVIDEND_W = CLK_W,
   parameter int DIVISOR_W  = CLK_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    partial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // One restoring step: bring down the next dividend bit and try to subtract.
   always_comb begin
      partial = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff    = partial - {1'b0, dvs_ff};
      fits    = (partial >= {1'b0, dvs_ff});
   end

   // Next state of the divider.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_LAST;
         dvd_in  = dividend;
         dvs_in  = divisor;
         quo_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // The result pulse comes only once the iteration has stopped.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still iterating");

   // A new division is never launched over a running one.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   // The remainder ends below the divisor.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ((dvs_ff == '0) || (rem_ff < dvs_ff)))
      else $error("divider remainder not below divisor");

endmodule

// ----- sv/cbts_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit timing search datapath
// Holds the rate register, the search state, the candidate scoring and the
// result registers. Shares one divider between the search and the final rate.
// ----------------------------------------------------------------------------
module cbts_datapath
   import cbts_pkg::*;
#(
   parameter int MAX_PRESCALER = MAX_PRESCALER_DEF,
   parameter int MAX_QUANTA    = MAX_QUANTA_DEF,
   parameter int MIN_QUANTA    = MIN_QUANTA_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cbts_cmd_type         cmd,
   output cbts_status_type      status,
   input  logic [OSC_W-1:0]     req_oscillator_hz,
   input  logic                 csr_we,
   input  logic [RATE_W-1:0]    csr_wdata,
   output logic                 rsp_valid,
   output logic [PRESC_W-1:0]   rsp_prescaler,
   output logic [QUANTA_W-1:0]  rsp_quanta_per_bit,
   output logic [BITRATE_W-1:0] rsp_actual_bit_rate,
   output logic [BITRATE_W-1:0] rsp_rate_error
);

   localparam int QMAX = (MAX_QUANTA > MIN_QUANTA) ? MAX_QUANTA : MIN_QUANTA;
   localparam int QW   = $clog2(QMAX + 1);
   localparam int PW   = $clog2(MAX_PRESCALER + 1);
   localparam int DVW  = ((PW > RATE_W) ? PW : RATE_W) + QW;

   localparam logic [QW-1:0]    Q_MAX   = QW'(MAX_QUANTA);
   localparam logic [QW-1:0]    Q_MIN   = QW'(MIN_QUANTA);
   localparam logic [PW-1:0]    P_MAX   = PW'(MAX_PRESCALER);
   localparam logic [CLK_W-1:0] P_LIMIT = CLK_W'(MAX_PRESCALER);

   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic                 found_ff, found_in;
   logic                 rsp_valid_ff;
   logic [CLK_W-1:0]     clk_ff, clk_in;
   logic [QW-1:0]        q_ff, q_in;
   logic [DVW-1:0]       step_ff, step_in;
   logic [DVW-1:0]       final_ff, final_in;
   logic [PW-1:0]        best_p_ff, best_p_in;
   logic [QW-1:0]        best_q_ff, best_q_in;
   logic [DVW-1:0]       best_err_ff, best_err_in;
   logic [PRESC_W-1:0]   rsp_prescaler_ff, rsp_prescaler_in;
   logic [QUANTA_W-1:0]  rsp_quanta_ff, rsp_quanta_in;
   logic [BITRATE_W-1:0] rsp_actual_ff, rsp_actual_in;
   logic [BITRATE_W-1:0] rsp_error_ff, rsp_error_in;

   logic [DVW-1:0]       div_divisor;
   logic                 div_done;
   logic [CLK_W-1:0]     div_quo;
   logic [DVW-1:0]       div_rem;

   logic                 over;
   logic                 take_floor, take_ceil;
   logic [DVW-1:0]       err_ceil;
   logic [DVW-1:0]       err_a, err_b;
   logic                 found_a, found_b;
   logic [CLK_W-1:0]     rate_ext;
   logic [CLK_W-1:0]     rate_diff;

   // Shared divider: the search divides the clock by the step, the final
   // pass by the chosen prescaler times quanta.
   assign div_divisor = cmd.div_final ? final_ff : step_ff;

   cbts_div #(
      .DIVIDEND_W (CLK_W),
      .DIVISOR_W  (DVW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (clk_ff),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Candidate scoring. The floor error is the remainder and the error of
   // the floor plus one is the step less the remainder.
   always_comb begin
      over       = (div_quo > P_LIMIT);
      err_ceil   = step_ff - div_rem;
      take_floor = (div_quo != '0) && !over && (!found_ff || (div_rem < best_err_ff));
      err_a      = take_floor ? div_rem : best_err_ff;
      found_a    = found_ff | take_floor;
      take_ceil  = (div_quo < P_LIMIT) && (!found_a || (err_ceil < err_a));
      err_b      = take_ceil ? err_ceil : err_a;
      found_b    = found_a | take_ceil;
   end

   // Status back to the controller.
   always_comb begin
      status.skip     = (step_ff == '0) || (q_ff < Q_MIN);
      status.div_done = div_done;
      status.stop     = over || (found_b && (err_b == '0));
      status.q_last   = (q_ff <= Q_MIN);
   end

   // Final absolute rate error.
   always_comb begin
      rate_ext  = CLK_W'(rate_ff);
      rate_diff = (div_quo >= rate_ext) ? (div_quo - rate_ext) : (rate_ext - div_quo);
   end

   // Next values of the search and result registers.
   always_comb begin
      rate_in          = csr_we ? csr_wdata : rate_ff;
      found_in         = found_ff;
      clk_in           = clk_ff;
      q_in             = q_ff;
      step_in          = step_ff;
      final_in         = final_ff;
      best_p_in        = best_p_ff;
      best_q_in        = best_q_ff;
      best_err_in      = best_err_ff;
      rsp_prescaler_in = rsp_prescaler_ff;
      rsp_quanta_in    = rsp_quanta_ff;
      rsp_actual_in    = rsp_actual_ff;
      rsp_error_in     = rsp_error_ff;
      if (cmd.load) begin
         clk_in    = req_oscillator_hz[OSC_W-1:1];
         q_in      = Q_MAX;
         found_in  = 1'b0;
         best_p_in = P_MAX;
         best_q_in = Q_MAX;
      end
      if (cmd.mul_step) begin
         step_in = DVW'(rate_ff) * DVW'(q_ff);
      end
      if (cmd.eval) begin
         found_in    = found_b;
         best_err_in = err_b;
         if (take_ceil) begin
            best_p_in = PW'(div_quo) + 1'b1;
            best_q_in = q_ff;
         end else if (take_floor) begin
            best_p_in = PW'(div_quo);
            best_q_in = q_ff;
         end
      end
      if (cmd.dec_q) begin
         q_in = q_ff - 1'b1;
      end
      if (cmd.mul_final) begin
         final_in = DVW'(best_p_ff) * DVW'(best_q_ff);
      end
      if (cmd.finish) begin
         rsp_prescaler_in = PRESC_W'(best_p_ff);
         rsp_quanta_in    = QUANTA_W'(best_q_ff);
         rsp_actual_in    = BITRATE_W'(div_quo);
         rsp_error_in     = BITRATE_W'(rate_diff);
      end
   end

   // Control registers and the rate register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= RATE_RESET;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rate_ff      <= rate_in;
         found_ff     <= found_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      clk_ff           <= clk_in;
      q_ff             <= q_in;
      step_ff          <= step_in;
      final_ff         <= final_in;
      best_p_ff        <= best_p_in;
      best_q_ff        <= best_q_in;
      best_err_ff      <= best_err_in;
      rsp_prescaler_ff <= rsp_prescaler_in;
      rsp_quanta_ff    <= rsp_quanta_in;
      rsp_actual_ff    <= rsp_actual_in;
      rsp_error_ff     <= rsp_error_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_prescaler       = rsp_prescaler_ff;
   assign rsp_quanta_per_bit  = rsp_quanta_ff;
   assign rsp_actual_bit_rate = rsp_actual_ff;
   assign rsp_rate_error      = rsp_error_ff;

   // A recorded candidate never has a zero prescaler.
   a_best_nonzero: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (best_p_ff != '0))
      else $error("best prescaler is zero");

   // The result strobe lasts one cycle per beat.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   // Scoring never lowers the error without recording a candidate.
   a_eval_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && (take_floor || take_ceil)) |=> found_ff)
      else $error("candidate taken but not recorded");

endmodule

// ----- sv/cbts_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit timing search controller
// Sequences the quanta search, the final rate division and the result beat.
// ----------------------------------------------------------------------------
module cbts_ctrl
   import cbts_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  cbts_status_type status,
   output cbts_cmd_type    cmd
);

   cbts_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_STEP_MUL;
            end
         end
         ST_STEP_MUL: begin
            state_in = ST_STEP_CHK;
         end
         ST_STEP_CHK: begin
            state_in = status.skip ? ST_FIN_MUL : ST_SEARCH_WAIT;
         end
         ST_SEARCH_WAIT: begin
            if (status.div_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.stop || status.q_last) begin
               state_in = ST_FIN_MUL;
            end else begin
               state_in = ST_STEP_MUL;
            end
         end
         ST_FIN_MUL: begin
            state_in = ST_FIN_DIV;
         end
         ST_FIN_DIV: begin
            state_in = ST_FIN_WAIT;
         end
         ST_FIN_WAIT: begin
            if (status.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands for each state.
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_STEP_MUL: begin
            cmd.mul_step = 1'b1;
         end
         ST_STEP_CHK: begin
            cmd.div_start = !status.skip;
         end
         ST_EVAL: begin
            cmd.eval  = 1'b1;
            cmd.dec_q = !(status.stop || status.q_last);
         end
         ST_FIN_MUL: begin
            cmd.mul_final = 1'b1;
         end
         ST_FIN_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_final = 1'b1;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // Every accepted beat starts the search with a step product.
   a_accept_step: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_STEP_MUL))
      else $error("accepted beat did not start the search");

   // The result beat is followed by a return to idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy)
      else $error("controller stayed busy after the result beat");

   // A divider result only shows up while the controller waits for one.
   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> ((state_ff == ST_SEARCH_WAIT) || (state_ff == ST_FIN_WAIT)))
      else $error("divider result outside a wait state");

endmodule

// ----- sv/can_bit_timing_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit timing search
// Picks the baud rate prescaler and quanta per bit that bring half the
// oscillator frequency closest to the requested CAN bit rate.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Handshake
//  request   start, busy, req_*             taken when start and not busy
//  result    rsp_valid, rsp_*               one-cycle strobe, no stall
//  csr       csr_we, csr_wdata              written when csr_we is high
//
//  Each quanta value tried runs the 26-step shared divider once, and the
//  final rate division runs it once more. A zero requested rate skips
//  the search and goes straight on to the final rate division.
//  Reset is synchronous and restores the requested rate to 615000.
//  One beat is worked at a time; busy stays high until the strobe cycle.
//  The receiver cannot stall the result; it is shown for one cycle only.
// ----------------------------------------------------------------------------
module can_bit_timing_search
   import cbts_pkg::*;
#(
   parameter int MAX_PRESCALER = MAX_PRESCALER_DEF,
   parameter int MAX_QUANTA    = MAX_QUANTA_DEF,
   parameter int MIN_QUANTA    = MIN_QUANTA_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OSC_W-1:0]     req_oscillator_hz,
   input  logic                 csr_we,
   input  logic [RATE_W-1:0]    csr_wdata,
   output logic                 rsp_valid,
   output logic [PRESC_W-1:0]   rsp_prescaler,
   output logic [QUANTA_W-1:0]  rsp_quanta_per_bit,
   output logic [BITRATE_W-1:0] rsp_actual_bit_rate,
   output logic [BITRATE_W-1:0] rsp_rate_error
);

   cbts_cmd_type    cmd;
   cbts_status_type status;

   // Search sequencer.
   cbts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Arithmetic and result registers.
   cbts_datapath #(
      .MAX_PRESCALER (MAX_PRESCALER),
      .MAX_QUANTA    (MAX_QUANTA),
      .MIN_QUANTA    (MIN_QUANTA)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_oscillator_hz   (req_oscillator_hz),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_prescaler       (rsp_prescaler),
      .rsp_quanta_per_bit  (rsp_quanta_per_bit),
      .rsp_actual_bit_rate (rsp_actual_bit_rate),
      .rsp_rate_error      (rsp_rate_error)
   );

endmodule
